@@ rtl/brf_pkg.sv @@
// Shared types and constants for the circular byte FIFO.
`default_nettype none

package brf_pkg;

  localparam int CAP_W       = 6;
  localparam int CNT_W       = 6;
  localparam int BYTE_W      = 8;
  localparam int DATA_FIELDS = 8;
  localparam int LANE_IW     = $clog2(DATA_FIELDS);

  // configuration register indexes
  localparam int REG_CAPACITY = 0;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_DUMP  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_EMPTY   = 2'd2
  } status_t;

  // work handed from the classifier to the execution side
  typedef enum logic [2:0] {
    OP_STATUS = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_WRITE  = 3'd2,
    OP_READ   = 3'd3,
    OP_DUMP   = 3'd4
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [CNT_W-1:0]         n;
    status_t                  status;
    logic [CAP_W-1:0]         used;
    logic [CAP_W-1:0]         free;
    byte_t [DATA_FIELDS-1:0]  data;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/byte_ring_fifo_unit.sv @@
// Top level of the circular byte FIFO: APB register, front end, queue, back end, store.
//
// A byte FIFO on a ring of capacity+1 byte slots. An item is taken when start is high
// and busy is low; busy only rises while the two-entry command queue is full. Results
// come out on result_valid for one cycle each and cannot be held off. After an item is
// taken, the back end picks it up from the queue once idle and then moves one byte at
// a time through the store: a write burst of n bytes gives its single result after its
// last byte is written, a read or dump of n bytes gives n results on consecutive cycles,
// and a status-only item (refused, empty, clear, zero-length) gives its result when the
// back end picks it up. The single byte store port sets this pace. Writing the capacity
// register empties the FIFO and must only be done while the block is idle.
`default_nettype none

module byte_ring_fifo_unit import brf_pkg::*; #(
  parameter int MAX_CAPACITY = 63,
  parameter int WRITE_LANES  = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  // item channel
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          kind,
  input  wire logic [CNT_W-1:0]    count,
  input  wire logic [BYTE_W-1:0]   data_0,
  input  wire logic [BYTE_W-1:0]   data_1,
  input  wire logic [BYTE_W-1:0]   data_2,
  input  wire logic [BYTE_W-1:0]   data_3,
  input  wire logic [BYTE_W-1:0]   data_4,
  input  wire logic [BYTE_W-1:0]   data_5,
  input  wire logic [BYTE_W-1:0]   data_6,
  input  wire logic [BYTE_W-1:0]   data_7,
  // result channel
  output logic                     result_valid,
  output logic [1:0]               status,
  output logic                     has_byte,
  output logic [BYTE_W-1:0]        byte_out,
  output logic                     last,
  output logic [CAP_W-1:0]         bytes_used,
  output logic [CAP_W-1:0]         bytes_free
);

  localparam int PW        = $clog2(MAX_CAPACITY + 1);
  localparam int CAP_RESET = (63 > MAX_CAPACITY) ? MAX_CAPACITY : 63;

  logic                    cfg_clear;
  logic [CAP_W-1:0]        capacity;
  logic [CAP_W-1:0]        cap_wr;
  byte_t [DATA_FIELDS-1:0] data_in;
  logic                    take;
  cmd_t                    front_cmd, head;
  logic                    q_full, q_empty, pop;
  logic                    ram_we;
  logic [PW-1:0]           ram_waddr, ram_raddr;
  byte_t                   ram_wdata, ram_rdata;

  // register write decode, register index from the word address
  assign pready    = 1'b1;
  assign cfg_clear = psel && penable && pwrite && pready &&
                     (32'(paddr[2]) == 32'(REG_CAPACITY));

  // saturate the written capacity into 1..MAX_CAPACITY
  always_comb begin
    cap_wr = pwdata[CAP_W-1:0];
    if (cap_wr == '0) begin
      cap_wr = CAP_W'(1);
    end
    if (int'(cap_wr) > MAX_CAPACITY) begin
      cap_wr = CAP_W'(MAX_CAPACITY);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(CAP_RESET);
    end else if (cfg_clear) begin
      capacity <= cap_wr;
    end
  end

  always_comb begin
    prdata = '0;
    if (32'(paddr[2]) == 32'(REG_CAPACITY)) begin
      prdata = 32'(capacity);
    end
  end

  // item transfer
  assign busy = q_full;
  assign take = start && !busy;

  assign data_in[0] = data_0;
  assign data_in[1] = data_1;
  assign data_in[2] = data_2;
  assign data_in[3] = data_3;
  assign data_in[4] = data_4;
  assign data_in[5] = data_5;
  assign data_in[6] = data_6;
  assign data_in[7] = data_7;

  brf_front #(
    .MAX_CAPACITY (MAX_CAPACITY),
    .WRITE_LANES  (WRITE_LANES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .cfg_clear (cfg_clear),
    .capacity  (capacity),
    .kind      (kind),
    .count     (count),
    .data      (data_in),
    .cmd       (front_cmd)
  );

  brf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (take),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  brf_back #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_clear    (cfg_clear),
    .capacity     (capacity),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .result_valid (result_valid),
    .status       (status),
    .has_byte     (has_byte),
    .byte_out     (byte_out),
    .last         (last),
    .bytes_used   (bytes_used),
    .bytes_free   (bytes_free)
  );

  brf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_CAPACITY + 1)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

@@ rtl/brf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/brf_queue.sv @@
// Two-entry command queue between the classifier and the execution side.
`default_nettype none

module brf_queue import brf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      full,
  output logic      empty
);

  localparam int QD = 2;

  cmd_t             slot [QD];
  logic             wr_sel;
  logic             rd_sel;
  logic [1:0]       fill;

  assign full  = (fill == 2'(QD));
  assign empty = (fill == 2'd0);
  assign head  = slot[rd_sel];

  // entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wr_sel] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_sel <= ~wr_sel;
      end
      if (pop && !empty) begin
        rd_sel <= ~rd_sel;
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/brf_front.sv @@
// Front end: accepts items, tracks committed pointers, classifies into commands.
`default_nettype none

module brf_front import brf_pkg::*; #(
  parameter int MAX_CAPACITY = 63,
  parameter int WRITE_LANES  = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    take,
  input  wire logic                    cfg_clear,
  input  wire logic [CAP_W-1:0]        capacity,
  input  wire logic [1:0]              kind,
  input  wire logic [CNT_W-1:0]        count,
  input  byte_t [DATA_FIELDS-1:0]      data,
  output cmd_t                         cmd
);

  localparam int PW    = $clog2(MAX_CAPACITY + 1);
  localparam int AW    = ((PW > CAP_W) ? PW : CAP_W) + 1;
  localparam int LANES = (WRITE_LANES < DATA_FIELDS) ? WRITE_LANES : DATA_FIELDS;

  logic [PW-1:0]    wr_ptr, wr_ptr_next;
  logic [PW-1:0]    rd_ptr, rd_ptr_next;
  logic [AW-1:0]    wp_x, rp_x, cap_x, slots_x, used_x, wsum, rsum;
  logic [CAP_W-1:0] used, free;
  logic [CNT_W-1:0] n_read;

  // occupancy from the committed pointers
  always_comb begin
    wp_x    = AW'(wr_ptr);
    rp_x    = AW'(rd_ptr);
    cap_x   = AW'(capacity);
    slots_x = cap_x + AW'(1);
    used_x  = (wp_x >= rp_x) ? (wp_x - rp_x) : (wp_x + slots_x - rp_x);
    used    = used_x[CAP_W-1:0];
    free    = capacity - used;
    n_read  = (count < used) ? count : used;
    wsum    = wp_x + AW'(count);
    rsum    = rp_x + AW'(n_read);
  end

  // classification
  always_comb begin
    cmd         = '0;
    cmd.data    = data;
    cmd.op      = OP_STATUS;
    cmd.status  = ST_OK;
    cmd.used    = used;
    cmd.free    = free;
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    case (kind_t'(kind))
      KIND_WRITE: begin
        if (count > CNT_W'(LANES) || count > free) begin
          cmd.status = ST_REFUSED;
        end else if (count != '0) begin
          cmd.op      = OP_WRITE;
          cmd.n       = count;
          cmd.used    = used + count;
          cmd.free    = free - count;
          wr_ptr_next = (wsum > cap_x) ? PW'(wsum - slots_x) : PW'(wsum);
        end
      end
      KIND_CLEAR: begin
        cmd.op      = OP_CLEAR;
        cmd.used    = '0;
        cmd.free    = capacity;
        wr_ptr_next = '0;
        rd_ptr_next = '0;
      end
      KIND_READ: begin
        if (used == '0) begin
          cmd.status = ST_EMPTY;
        end else if (n_read != '0) begin
          cmd.op      = OP_READ;
          cmd.n       = n_read;
          cmd.used    = used - n_read;
          cmd.free    = free + n_read;
          rd_ptr_next = (rsum > cap_x) ? PW'(rsum - slots_x) : PW'(rsum);
        end
      end
      default: begin
        // dump: stream everything, remove nothing
        if (used == '0) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.op = OP_DUMP;
          cmd.n  = used;
        end
      end
    endcase
  end

  // committed pointers
  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else if (take) begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/brf_back.sv @@
// Back end: executes queued commands against the byte store and drives results.
`default_nettype none

module brf_back import brf_pkg::*; #(
  parameter int MAX_CAPACITY = 63
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_clear,
  input  wire logic [CAP_W-1:0]                     capacity,
  input  cmd_t                                      head,
  input  wire logic                                 q_empty,
  output logic                                      pop,
  output logic                                      ram_we,
  output logic [$clog2(MAX_CAPACITY + 1)-1:0]       ram_waddr,
  output byte_t                                     ram_wdata,
  output logic [$clog2(MAX_CAPACITY + 1)-1:0]       ram_raddr,
  input  byte_t                                     ram_rdata,
  output logic                                      result_valid,
  output logic [1:0]                                status,
  output logic                                      has_byte,
  output byte_t                                     byte_out,
  output logic                                      last,
  output logic [CAP_W-1:0]                          bytes_used,
  output logic [CAP_W-1:0]                          bytes_free
);

  localparam int PW = $clog2(MAX_CAPACITY + 1);
  localparam int AW = ((PW > CAP_W) ? PW : CAP_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WRITE = 3'b010,
    S_READ  = 3'b100
  } state_t;

  state_t           state;
  cmd_t             cmd;
  logic [CNT_W-1:0] idx;
  logic             at_end;
  logic [PW-1:0]    wr_ptr, rd_ptr, cur;
  logic [PW-1:0]    wr_ptr_inc, cur_inc;

  // wrap at the last slot, which sits at index capacity
  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p,
                                         input logic [CAP_W-1:0] cap);
    logic [AW-1:0] px;
    px = AW'(p);
    return (px == AW'(cap)) ? '0 : PW'(px + AW'(1));
  endfunction

  assign wr_ptr_inc = bump(wr_ptr, capacity);
  assign cur_inc    = bump(cur, capacity);
  assign at_end     = (idx == (cmd.n - CNT_W'(1)));

  assign pop       = (state == S_IDLE) && !q_empty;
  assign ram_we    = (state == S_WRITE);
  assign ram_waddr = wr_ptr;
  assign ram_wdata = cmd.data[idx[LANE_IW-1:0]];
  assign ram_raddr = cur;
  assign byte_out  = has_byte ? ram_rdata : '0;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      wr_ptr       <= '0;
      rd_ptr       <= '0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_clear) begin
        wr_ptr <= '0;
        rd_ptr <= '0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cmd        <= head;
            idx        <= '0;
            cur        <= rd_ptr;
            status     <= head.status;
            has_byte   <= 1'b0;
            last       <= 1'b1;
            bytes_used <= head.used;
            bytes_free <= head.free;
            case (head.op)
              OP_WRITE: state <= S_WRITE;
              OP_READ:  state <= S_READ;
              OP_DUMP:  state <= S_READ;
              OP_CLEAR: begin
                wr_ptr       <= '0;
                rd_ptr       <= '0;
                result_valid <= 1'b1;
              end
              default:  result_valid <= 1'b1;
            endcase
          end
        end
        S_WRITE: begin
          // one byte into the store per cycle, result after the last one
          wr_ptr <= wr_ptr_inc;
          idx    <= idx + CNT_W'(1);
          if (at_end) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_READ: begin
          // address goes out now, byte and strobe line up next cycle
          cur          <= cur_inc;
          idx          <= idx + CNT_W'(1);
          result_valid <= 1'b1;
          status       <= ST_OK;
          has_byte     <= 1'b1;
          last         <= at_end;
          if (at_end) begin
            if (cmd.op == OP_READ) begin
              rd_ptr <= cur_inc;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
